### design/gvm_pkg.sv
// Shared types and constants for the GF(2) vector-times-matrix block.
// Used by the front queue, the back engine and the top level; no dependencies.
package gvm_pkg;

  localparam int DATA_W        = 64;
  localparam int ROW_COUNT     = 64;
  localparam int ROW_IDX_W     = $clog2(ROW_COUNT);
  localparam int WORD_BITS_DEF = 64;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  // Kind of an input beat, as carried in tuser.
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MUL  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [ROW_IDX_W-1:0]   row;
    logic [DATA_W-1:0]      data;
    logic                   last;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_RUN  = 2'd1,
    B_FIN  = 2'd2
  } back_state_t;

endpackage

### design/gvm_front.sv
// Front part: accepts input beats, classifies them as load or multiply commands
// and holds them in a short queue for the back engine. Depends on gvm_pkg.
module gvm_front
  import gvm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [71:0]          s_tdata,   // row_index [5:0], data_word [69:6], zero pad
  input  logic                 s_tuser,   // action
  input  logic                 s_tlast,   // last_vector
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  input  logic                 cmd_pop
);

  cmd_t                   queue [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  cmd_t                   cmd_in;
  logic                   push;
  logic                   pop;

  always_comb begin
    cmd_in.kind = cmd_kind_t'(s_tuser);
    cmd_in.row  = s_tdata[ROW_IDX_W-1:0];
    cmd_in.data = s_tdata[ROW_IDX_W +: DATA_W];
    cmd_in.last = s_tlast;
  end

  assign s_tready  = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/gvm_back.sv
// Back part: holds the matrix memory, writes rows for load commands and walks
// the rows one per cycle for multiply commands, then presents the product.
// Depends on gvm_pkg.
module gvm_back
  import gvm_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 transpose_mode,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,
  output logic                 m_tlast
);

  localparam logic [ROW_IDX_W-1:0] LAST_IDX = ROW_IDX_W'(WORD_BITS - 1);

  logic [DATA_W-1:0]    mem [ROW_COUNT];
  back_state_t          state;
  back_state_t          state_next;
  logic [ROW_IDX_W-1:0] cnt;
  logic [ROW_IDX_W-1:0] rd_idx;
  logic                 rd_vld;
  logic [DATA_W-1:0]    rd_data;
  logic [DATA_W-1:0]    vec;
  logic                 last_r;
  logic [DATA_W-1:0]    acc;
  logic [DATA_W-1:0]    acc_upd;
  logic [DATA_W-1:0]    acc_eff;
  logic                 mem_we;
  logic                 issue;
  logic                 start;
  logic                 out_load;
  logic                 par;

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    issue      = 1'b0;
    start      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_LOAD) begin
            mem_we = 1'b1;
          end else begin
            start      = 1'b1;
            state_next = B_RUN;
          end
        end
      end
      B_RUN: begin
        issue = 1'b1;
        if (cnt == LAST_IDX) begin
          state_next = B_FIN;
        end
      end
      B_FIN: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // One row's contribution: a selected row in normal mode, a parity bit in
  // transposed mode.
  always_comb begin
    par = ^(vec & rd_data);
    if (transpose_mode) begin
      acc_upd = acc | (DATA_W'(par) << rd_idx);
    end else begin
      acc_upd = vec[rd_idx] ? (acc ^ rd_data) : acc;
    end
    acc_eff = rd_vld ? acc_upd : acc;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.row] <= cmd.data;
    end
    if (issue) begin
      rd_data <= mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (start) begin
      cnt    <= '0;
      acc    <= '0;
      vec    <= cmd.data;
      last_r <= cmd.last;
    end else begin
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (rd_vld) begin
        acc <= acc_upd;
      end
    end
    if (out_load) begin
      m_tdata <= acc_eff;
      m_tlast <= last_r;
    end
  end

endmodule

### design/gf2_vector_times_matrix.sv
// GF(2) vector times 64x64 bit matrix, streaming in and out.
// With the engine idle, a load beat writes its row in the cycle after acceptance; a multiply
// is queued, walks the rows in the engine and then registers its product.
// The engine finishes one multiply before it pops the next command; the single read
// port of the matrix memory is read one row per cycle.
// Reset (rst, synchronous) clears the queue, the engine and transpose_mode.
module gf2_vector_times_matrix
  import gvm_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: transpose_mode, written whenever cfg_we is high.
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // Input beats.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // row_index [5:0], data_word [69:6], zero pad [71:70]
  input  logic        s_tuser,   // action: 0 loads a row, 1 multiplies a vector
  input  logic        s_tlast,   // last_vector
  // Result beats.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // product_word [63:0]
  output logic        m_tlast    // last_out
);

  // The user must change the mode register only while the block is idle (the block does not
  // enforce this), so the back engine may read it directly during a multiply.
  logic transpose_mode;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      transpose_mode <= 1'b0;
    end else if (cfg_we) begin
      transpose_mode <= cfg_wdata;
    end
  end

  // The front classifies each beat and queues it, so the input side keeps
  // accepting, until the queue is full, while the engine walks through the rows.
  gvm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // The back engine executes commands in order, so a load never overtakes a
  // multiply that was accepted before it.
  gvm_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .transpose_mode (transpose_mode),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast)
  );

endmodule

### sim/tb_gf2_vector_times_matrix.sv
// Self-checking testbench for gf2_vector_times_matrix: loads matrix rows, streams vectors
// in both multiply modes and checks every product beat against an in-bench predictor.
// Depends on gvm_pkg and the gf2_vector_times_matrix RTL; nothing else.
module tb_gf2_vector_times_matrix;
  import gvm_pkg::*;

  localparam int WORD_BITS   = WORD_BITS_DEF;
  // Settling pause: longer than a multiply takes with the output ready.
  localparam int SETTLE      = WORD_BITS + 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 5;
  localparam int PHASE_BEATS = 260;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // row_index [5:0], data_word [69:6], zero pad [71:70]
  logic        s_tuser;   // action: 0 loads a row, 1 multiplies a vector
  logic        s_tlast;   // last_vector
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // product_word [63:0]
  logic        m_tlast;   // last_out

  gf2_vector_times_matrix #(.WORD_BITS(WORD_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // One product beat as the block should deliver it.
  typedef struct {
    logic [63:0] word;
    logic        last;
  } product_t;

  // One line of the directed table. Where typed is set, want is the product read straight
  // off the rows loaded above it; otherwise the predictor supplies the expectation.
  typedef struct {
    cmd_kind_t   kind;
    logic [5:0]  row;
    logic [63:0] data;
    logic        last;
    bit          typed;
    logic [63:0] want;
  } plan_row_t;

  // Our own copy of the matrix and of the mode register, kept in step with every beat
  // accepted and every register write.
  logic [63:0] matrix_copy [ROW_COUNT];
  logic        transposed;

  product_t  products_due [$];
  plan_row_t directed_plan [$];

  int unsigned mismatches;
  int unsigned cycle_count;
  bit          calm;       // set for the last phase: no idling on either side
  bit          hold_req;   // asks the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a correct run ends well inside this many cycles.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d products outstanding", cycle_count,
               products_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Product of a vector with the stored matrix. In normal mode every row selected by a set
  // vector bit is XORed in; in transposed mode each product bit is the parity of the
  // vector masked by the corresponding row.
  function automatic logic [63:0] gf2_product(input logic [63:0] vec);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < WORD_BITS && i < ROW_COUNT; i++) begin
      if (transposed) begin
        acc[i] = ^(vec & matrix_copy[i]);
      end else if (vec[i]) begin
        acc ^= matrix_copy[i];
      end
    end
    return acc;
  endfunction

  task automatic plan(input cmd_kind_t kind, input logic [5:0] row, input logic [63:0] data,
                      input logic last, input bit typed, input logic [63:0] want);
    plan_row_t entry;
    entry.kind  = kind;
    entry.row   = row;
    entry.data  = data;
    entry.last  = last;
    entry.typed = typed;
    entry.want  = want;
    directed_plan.push_back(entry);
  endtask

  // Offers one input beat and holds it until the block takes it. The valid line is left
  // high on return so that back-to-back beats stay back to back; an idle burst, when one
  // is drawn, lowers it first. Prediction happens at the accepting edge.
  task automatic offer_beat(input cmd_kind_t kind, input logic [5:0] row,
                            input logic [63:0] data, input logic last,
                            input bit typed, input logic [63:0] want);
    product_t expected;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, data, row};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (kind == CMD_LOAD) begin
      matrix_copy[row] = data;
    end else begin
      expected.word = typed ? want : gf2_product(data);
      expected.last = last;
      products_due.push_back(expected);
    end
  endtask

  // Lets the block run dry: no beat offered, every product delivered, and then a settling
  // pause, since a load beat leaves no product to wait for.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (products_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mode register writes happen only with the block drained.
  task automatic write_transpose(input logic mode);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    transposed = mode;
  endtask

  // Result side: checks each accepted beat against the oldest expectation, then decides
  // whether to be ready in the next cycle. Idle bursts and the single long hold-off are
  // both counted here, so the sender keeps pushing while the output is blocked.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    product_t    expected;
    stall_left = 0;
    hold_left  = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (m_tvalid && m_tready) begin
        if (products_due.size() == 0) begin
          note_mismatch("unexpected product beat", m_tdata, '0);
        end else begin
          expected = products_due.pop_front();
          if (m_tdata !== expected.word) begin
            note_mismatch("product_word", m_tdata, expected.word);
          end
          if (m_tlast !== expected.last) begin
            note_mismatch("last_out", 64'(m_tlast), 64'(expected.last));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [63:0] word;
    int unsigned bit_pos;
    logic [5:0]  row;

    mismatches  = 0;
    cycle_count = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    transposed  = 1'b0;
    foreach (matrix_copy[i]) matrix_copy[i] = '0;

    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_LOAD;
    s_tlast   <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, in the reset mode (normal). Only rows 0, 1, 5 and 63 are loaded, so
    // every vector below selects loaded rows only. The last flag on a load must be ignored.
    plan(CMD_LOAD, 6'd0,  '1,                     1'b1, 1'b0, '0);
    plan(CMD_LOAD, 6'd63, 64'h8000_0000_0000_0001, 1'b0, 1'b0, '0);
    plan(CMD_LOAD, 6'd1,  '0,                     1'b1, 1'b0, '0);
    plan(CMD_LOAD, 6'd5,  64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0, '0);
    plan(CMD_MUL,  6'd0,  '0,                     1'b0, 1'b1, '0);
    plan(CMD_MUL,  6'd63, 64'h1,                  1'b1, 1'b1, '1);
    plan(CMD_MUL,  6'd17, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 64'h8000_0000_0000_0001);
    plan(CMD_MUL,  6'd0,  64'h8000_0000_0000_0001, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE);
    plan(CMD_MUL,  6'd0,  64'h2,                  1'b0, 1'b1, '0);
    plan(CMD_MUL,  6'd0,  64'h20,                 1'b1, 1'b1, 64'hDEAD_BEEF_0123_4567);
    plan(CMD_MUL,  6'd0,  64'h8000_0000_0000_0023, 1'b0, 1'b1, 64'hA152_4110_FEDC_BA99);
    // Overwriting a row must take effect for the very next multiply.
    plan(CMD_LOAD, 6'd0,  '0,                     1'b0, 1'b0, '0);
    plan(CMD_MUL,  6'd0,  64'h1,                  1'b1, 1'b1, '0);
    plan(CMD_LOAD, 6'd63, '1,                     1'b1, 1'b0, '0);
    plan(CMD_MUL,  6'd63, 64'h8000_0000_0000_0023, 1'b1, 1'b1, 64'h2152_4110_FEDC_BA98);
    plan(CMD_MUL,  6'd0,  64'h8000_0000_0000_0021, 1'b0, 1'b0, '0);
    foreach (directed_plan[i]) begin
      offer_beat(directed_plan[i].kind, directed_plan[i].row, directed_plan[i].data,
                 directed_plan[i].last, directed_plan[i].typed, directed_plan[i].want);
    end

    // Fill the whole matrix before any random multiply, so that no product can read a
    // row that was never written, in either mode.
    for (int r = 0; r < ROW_COUNT; r++) begin
      offer_beat(CMD_LOAD, 6'(r), {$urandom, $urandom}, 1'(($urandom_range(0, 1))), 1'b0,
                 '0);
    end

    // Random phases, alternating the mode and starting with the transpose. One phase opens
    // with a long output hold-off so that the input side backs up; the last runs without
    // any idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_transpose(1'((phase + 1) % 2));
      calm = (phase == PHASES - 1);
      if (phase == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        bit_pos = $urandom_range(0, 63);
        case ($urandom_range(0, 7))
          0:       word = '0;
          1:       word = '1;
          2:       word = 64'd1 << bit_pos;
          3:       word = ~(64'd1 << bit_pos);
          default: word = {$urandom, $urandom};
        endcase
        row = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 9) < 3) begin
          offer_beat(CMD_LOAD, row, word, 1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          offer_beat(CMD_MUL, row, word, 1'($urandom_range(0, 3) == 0), 1'b0, '0);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
design/gvm_pkg.sv
design/gvm_front.sv
design/gvm_back.sv
design/gf2_vector_times_matrix.sv
sim/tb_gf2_vector_times_matrix.sv
